[hdl/mch_pkg.sv]
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants
// Widths, register indexes, the arctangent table and the data that each
// CORDIC cell carries alongside its rotating vector.
// ----------------------------------------------------------------------------
`default_nettype none

package mch_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_OFFSET_X = 3'd0;
    localparam logic [2:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [2:0] CFG_OFFSET_Z = 3'd2;
    localparam logic [2:0] CFG_GAIN_X   = 3'd3;
    localparam logic [2:0] CFG_GAIN_Y   = 3'd4;
    localparam logic [2:0] CFG_GAIN_Z   = 3'd5;
    localparam logic [2:0] CFG_BIAS_Z   = 3'd6;

    // Datapath widths
    localparam int RAW_W  = 16;
    localparam int CFG_W  = 24;
    localparam int NORM_W = 25;
    localparam int ROT_W  = 34;   // rotation x/y, Q2.30 with headroom
    localparam int ANG_W  = 34;   // binary angle accumulators
    localparam int VEC_W  = 60;   // vectoring x/y
    localparam int HDG_W  = 16;
    localparam int TAB_LEN = 24;

    localparam logic signed [ROT_W-1:0] INV_GAIN = 34'sd652032874;
    localparam logic signed [HDG_W-1:0] HDG_LIMIT = 16'sd23040;

    // atan(2^-i) in binary angle units, 2^32 per turn
    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Side data carried through the rotation cells
    typedef struct packed {
        logic signed [RAW_W-1:0] ax;
        logic signed [RAW_W-1:0] ay;
        logic signed [RAW_W-1:0] az;
        logic                    func;
        logic                    flip;
    } t_rside;

    // Side data carried through the vectoring cells
    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic                     den_zero;
        logic                     num_pos;
        logic                     num_neg;
    } t_vside;

endpackage

`default_nettype wire

[hdl/magnetometer_calibrate_heading.sv]
// Input to result: rotation cells, normalization, products, quotient setup, vectoring
// cells, output register. Two CORDIC chains of NS = min(CORDIC_STAGES, 24) one-cell stages.
// Throughput: one transaction per cycle unless output stalls; all cells advance together.
// The whole pipeline holds while a result waits and the output is not ready.
// Reset (synchronous, active low) drops all in-flight transactions and loads
// the calibration registers with their default values.
// ----------------------------------------------------------------------------
// magnetometer_calibrate_heading: calibrated compass heading
// Normalizes a three-axis sample, optionally corrects for roll, and returns
// the heading in Q8.8 degrees through two chains of CORDIC cells.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_calibrate_heading #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [23:0]        i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_axis_x,
    input  wire logic signed [15:0] i_axis_y,
    input  wire logic signed [15:0] i_axis_z,
    input  wire logic signed [15:0] i_roll_angle,
    input  wire logic               i_func,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_heading,
    output logic signed [24:0]      o_norm_x_out,
    output logic signed [24:0]      o_norm_y_out,
    output logic signed [24:0]      o_norm_z_out
);

    localparam int NS = (CORDIC_STAGES > mch_pkg::TAB_LEN) ? mch_pkg::TAB_LEN
                                                           : CORDIC_STAGES;
    localparam int RW = mch_pkg::ROT_W;
    localparam int AW = mch_pkg::ANG_W;
    localparam int VW = mch_pkg::VEC_W;

    logic ce;

    // Calibration registers
    logic signed [23:0] r_off_x, r_off_y, r_off_z, r_bias_z;
    logic        [23:0] r_gain_x, r_gain_y, r_gain_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x  <= -24'sd3192;
            r_off_y  <= -24'sd16437;
            r_off_z  <= -24'sd26312;
            r_gain_x <= 24'd94302;
            r_gain_y <= 24'd111071;
            r_gain_z <= 24'd93806;
            r_bias_z <= -24'sd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mch_pkg::CFG_OFFSET_X: r_off_x  <= i_cfg_wdata;
                mch_pkg::CFG_OFFSET_Y: r_off_y  <= i_cfg_wdata;
                mch_pkg::CFG_OFFSET_Z: r_off_z  <= i_cfg_wdata;
                mch_pkg::CFG_GAIN_X:   r_gain_x <= i_cfg_wdata;
                mch_pkg::CFG_GAIN_Y:   r_gain_y <= i_cfg_wdata;
                mch_pkg::CFG_GAIN_Z:   r_gain_z <= i_cfg_wdata;
                mch_pkg::CFG_BIAS_Z:   r_bias_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless a result is held
    logic r_out_vld;
    assign ce      = !r_out_vld || i_ready;
    assign o_ready = ce;

    // Roll angle into the right half plane; remember to negate afterwards
    logic [31:0]      w_ang;
    logic             w_flip;
    mch_pkg::t_rside  w_rside;
    assign w_flip = w_ang[31] ^ w_ang[30];
    assign w_ang  = {i_roll_angle, 16'd0};
    assign w_rside = '{ax: i_axis_x, ay: i_axis_y, az: i_axis_z,
                       func: i_func, flip: w_flip};

    // Rotation chain for sin/cos of the roll
    logic                 rot_vld  [0:NS];
    logic signed [RW-1:0] rot_x    [0:NS];
    logic signed [RW-1:0] rot_y    [0:NS];
    logic signed [AW-1:0] rot_z    [0:NS];
    mch_pkg::t_rside      rot_side [0:NS];

    assign rot_vld[0]  = i_valid;
    assign rot_x[0]    = mch_pkg::INV_GAIN;
    assign rot_y[0]    = '0;
    assign rot_z[0]    = {{(AW-32){w_ang[31] ^ w_flip}}, w_ang[31] ^ w_flip, w_ang[30:0]};
    assign rot_side[0] = w_rside;

    for (genvar g = 0; g < NS; g++) begin : g_rot
        mch_rot_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ce   (ce),
            .i_vld  (rot_vld[g]),
            .i_x    (rot_x[g]),
            .i_y    (rot_y[g]),
            .i_z    (rot_z[g]),
            .i_side (rot_side[g]),
            .o_vld  (rot_vld[g+1]),
            .o_x    (rot_x[g+1]),
            .o_y    (rot_y[g+1]),
            .o_z    (rot_z[g+1]),
            .o_side (rot_side[g+1])
        );
    end

    // Normalize the three axes
    logic signed [24:0] w_nx, w_ny, w_nz;

    mch_norm_axis u_norm_x (
        .i_clk(i_clk), .i_ce(ce), .i_raw(rot_side[NS].ax), .i_off(r_off_x),
        .i_gain(r_gain_x), .i_bias('0), .o_norm(w_nx)
    );
    mch_norm_axis u_norm_y (
        .i_clk(i_clk), .i_ce(ce), .i_raw(rot_side[NS].ay), .i_off(r_off_y),
        .i_gain(r_gain_y), .i_bias('0), .o_norm(w_ny)
    );
    mch_norm_axis u_norm_z (
        .i_clk(i_clk), .i_ce(ce), .i_raw(rot_side[NS].az), .i_off(r_off_z),
        .i_gain(r_gain_z), .i_bias(r_bias_z), .o_norm(w_nz)
    );

    // Carry sin/cos alongside normalization
    logic                 r_n1_vld, r_n2_vld, r_m_vld, r_p_vld;
    logic                 r_n1_func, r_n2_func, r_m_func;
    logic signed [RW-1:0] r_n1_s, r_n1_c, r_n2_s, r_n2_c;
    logic signed [58:0]   r_m_cy, r_m_sx;
    logic signed [24:0]   r_m_nx, r_m_ny, r_m_nz;
    logic signed [VW-1:0] r_p_num, r_p_den;
    logic signed [24:0]   r_p_nx, r_p_ny, r_p_nz;
    logic signed [VW-1:0] n_p_num, n_p_den;

    always_comb begin
        if (r_m_func) begin
            n_p_num = {r_m_cy[58], r_m_cy} - {r_m_sx[58], r_m_sx};
            n_p_den = {{(VW-55){r_m_nz[24]}}, r_m_nz, 30'd0};
        end else begin
            n_p_num = {{(VW-55){r_m_ny[24]}}, r_m_ny, 30'd0};
            n_p_den = {{(VW-55){r_m_nx[24]}}, r_m_nx, 30'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1_vld <= 1'b0;
            r_n2_vld <= 1'b0;
            r_m_vld  <= 1'b0;
            r_p_vld  <= 1'b0;
        end else if (ce) begin
            r_n1_vld <= rot_vld[NS];
            r_n2_vld <= r_n1_vld;
            r_m_vld  <= r_n2_vld;
            r_p_vld  <= r_m_vld;
        end
        if (ce) begin
            r_n1_func <= rot_side[NS].func;
            r_n1_s    <= rot_side[NS].flip ? -rot_y[NS] : rot_y[NS];
            r_n1_c    <= rot_side[NS].flip ? -rot_x[NS] : rot_x[NS];
            r_n2_func <= r_n1_func;
            r_n2_s    <= r_n1_s;
            r_n2_c    <= r_n1_c;
            r_m_func  <= r_n2_func;
            r_m_cy    <= r_n2_c * w_ny;
            r_m_sx    <= r_n2_s * w_nx;
            r_m_nx    <= w_nx;
            r_m_ny    <= w_ny;
            r_m_nz    <= w_nz;
            r_p_num   <= n_p_num;
            r_p_den   <= n_p_den;
            r_p_nx    <= r_m_nx;
            r_p_ny    <= r_m_ny;
            r_p_nz    <= r_m_nz;
        end
    end

    // Fold into the right half plane and flag a zero denominator
    logic                 vec_vld  [0:NS];
    logic signed [VW-1:0] vec_x    [0:NS];
    logic signed [VW-1:0] vec_y    [0:NS];
    logic signed [AW-1:0] vec_z    [0:NS];
    mch_pkg::t_vside      vec_side [0:NS];

    assign vec_vld[0] = r_p_vld;
    assign vec_x[0]   = r_p_den[VW-1] ? -r_p_den : r_p_den;
    assign vec_y[0]   = r_p_den[VW-1] ? -r_p_num : r_p_num;
    assign vec_z[0]   = '0;
    assign vec_side[0] = '{nx: r_p_nx, ny: r_p_ny, nz: r_p_nz,
                           den_zero: (r_p_den == '0),
                           num_pos: (r_p_num > 0),
                           num_neg: r_p_num[VW-1]};

    for (genvar g = 0; g < NS; g++) begin : g_vec
        mch_vec_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ce   (ce),
            .i_vld  (vec_vld[g]),
            .i_x    (vec_x[g]),
            .i_y    (vec_y[g]),
            .i_z    (vec_z[g]),
            .i_side (vec_side[g]),
            .o_vld  (vec_vld[g+1]),
            .o_x    (vec_x[g+1]),
            .o_y    (vec_y[g+1]),
            .o_z    (vec_z[g+1]),
            .o_side (vec_side[g+1])
        );
    end

    // Convert angle to Q8.8 degrees, clamp, apply special cases
    logic signed [AW+5:0] w_deg;
    logic signed [AW-16:0] w_hdg;
    logic signed [15:0]   n_hdg;
    assign w_deg = vec_z[NS] * (AW+6)'(45) + (AW+6)'(1 << 20);
    assign w_hdg = w_deg[AW+5:21];

    always_comb begin
        if (vec_side[NS].den_zero) begin
            if (vec_side[NS].num_pos) begin
                n_hdg = mch_pkg::HDG_LIMIT;
            end else if (vec_side[NS].num_neg) begin
                n_hdg = -mch_pkg::HDG_LIMIT;
            end else begin
                n_hdg = '0;
            end
        end else if (w_hdg > 19'sd23040) begin
            n_hdg = mch_pkg::HDG_LIMIT;
        end else if (w_hdg < -19'sd23040) begin
            n_hdg = -mch_pkg::HDG_LIMIT;
        end else begin
            n_hdg = w_hdg[15:0];
        end
    end

    // Output register
    logic signed [15:0] r_out_hdg;
    logic signed [24:0] r_out_nx, r_out_ny, r_out_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_out_vld <= vec_vld[NS];
        end
        if (ce) begin
            r_out_hdg <= n_hdg;
            r_out_nx  <= vec_side[NS].nx;
            r_out_ny  <= vec_side[NS].ny;
            r_out_nz  <= vec_side[NS].nz;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_heading    = r_out_hdg;
    assign o_norm_x_out = r_out_nx;
    assign o_norm_y_out = r_out_ny;
    assign o_norm_z_out = r_out_nz;

    // Checks
    a_hdg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading <= mch_pkg::HDG_LIMIT) && (o_heading >= -mch_pkg::HDG_LIMIT))
        else $error("heading out of range");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |-> !o_ready)
        else $error("input taken while result held");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ce && vec_vld[NS] && vec_side[NS].den_zero && !vec_side[NS].num_pos
         && !vec_side[NS].num_neg) |=> (o_heading == '0))
        else $error("zero over zero not zero heading");

endmodule

`default_nettype wire

[hdl/mch_norm_axis.sv]
// ----------------------------------------------------------------------------
// mch_norm_axis: one axis of hard-iron normalization
// Two stages: (raw - offset) * gain, then round to Q8.16, add bias, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_norm_axis (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_ce,
    input  wire logic signed [mch_pkg::RAW_W-1:0]     i_raw,
    input  wire logic signed [mch_pkg::CFG_W-1:0]     i_off,
    input  wire logic        [mch_pkg::CFG_W-1:0]     i_gain,
    input  wire logic signed [mch_pkg::CFG_W-1:0]     i_bias,
    output logic signed      [mch_pkg::NORM_W-1:0]    o_norm
);

    logic signed [24:0] w_diff;
    logic signed [24:0] w_gain;
    logic signed [49:0] n_prod;
    logic signed [49:0] r_prod;
    logic signed [24:0] r_bias;
    logic signed [49:0] w_rnd;
    logic signed [34:0] w_sum;
    logic signed [24:0] n_norm;
    logic signed [24:0] r_norm;

    // Remove offset in Q16.8 and scale
    assign w_diff = {i_raw[15], i_raw, 8'd0} - {i_off[23], i_off};
    assign w_gain = {1'b0, i_gain};
    assign n_prod = w_diff * w_gain;

    // Round half up, add bias, saturate
    assign w_rnd = r_prod + 50'sd32768;
    assign w_sum = {w_rnd[49], w_rnd[49:16]} + {{10{r_bias[24]}}, r_bias};
    always_comb begin
        if (w_sum > 35'sd16777215) begin
            n_norm = 25'sd16777215;
        end else if (w_sum < -35'sd16777216) begin
            n_norm = -25'sd16777216;
        end else begin
            n_norm = w_sum[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod <= n_prod;
            r_bias <= {i_bias[23], i_bias};
            r_norm <= n_norm;
        end
    end

    assign o_norm = r_norm;

endmodule

`default_nettype wire

[hdl/mch_rot_cell.sv]
// ----------------------------------------------------------------------------
// mch_rot_cell: one rotation-mode CORDIC cell
// Rotates (x, y) toward the residual angle by atan(2^-STAGE) and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_rot_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_ce,
    input  wire logic                               i_vld,
    input  wire logic signed [mch_pkg::ROT_W-1:0]   i_x,
    input  wire logic signed [mch_pkg::ROT_W-1:0]   i_y,
    input  wire logic signed [mch_pkg::ANG_W-1:0]   i_z,
    input  wire mch_pkg::t_rside                    i_side,
    output logic                                    o_vld,
    output logic signed      [mch_pkg::ROT_W-1:0]   o_x,
    output logic signed      [mch_pkg::ROT_W-1:0]   o_y,
    output logic signed      [mch_pkg::ANG_W-1:0]   o_z,
    output mch_pkg::t_rside                         o_side
);

    localparam logic signed [mch_pkg::ANG_W-1:0] ATAN =
        {2'b00, mch_pkg::ATAN_TAB[STAGE]};

    logic signed [mch_pkg::ROT_W-1:0] w_xs, w_ys;
    logic signed [mch_pkg::ROT_W-1:0] n_x, n_y, r_x, r_y;
    logic signed [mch_pkg::ANG_W-1:0] n_z, r_z;
    mch_pkg::t_rside r_side;
    logic r_vld;

    // Rotate by the sign of the residual angle
    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;
    always_comb begin
        if (!i_z[mch_pkg::ANG_W-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= i_vld;
        end
        if (i_ce) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

`default_nettype wire

[hdl/mch_vec_cell.sv]
// ----------------------------------------------------------------------------
// mch_vec_cell: one vectoring-mode CORDIC cell
// Drives y toward zero by atan(2^-STAGE) and accumulates the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_vec_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_ce,
    input  wire logic                               i_vld,
    input  wire logic signed [mch_pkg::VEC_W-1:0]   i_x,
    input  wire logic signed [mch_pkg::VEC_W-1:0]   i_y,
    input  wire logic signed [mch_pkg::ANG_W-1:0]   i_z,
    input  wire mch_pkg::t_vside                    i_side,
    output logic                                    o_vld,
    output logic signed      [mch_pkg::VEC_W-1:0]   o_x,
    output logic signed      [mch_pkg::VEC_W-1:0]   o_y,
    output logic signed      [mch_pkg::ANG_W-1:0]   o_z,
    output mch_pkg::t_vside                         o_side
);

    localparam logic signed [mch_pkg::ANG_W-1:0] ATAN =
        {2'b00, mch_pkg::ATAN_TAB[STAGE]};

    logic signed [mch_pkg::VEC_W-1:0] w_xs, w_ys;
    logic signed [mch_pkg::VEC_W-1:0] n_x, n_y, r_x, r_y;
    logic signed [mch_pkg::ANG_W-1:0] n_z, r_z;
    mch_pkg::t_vside r_side;
    logic r_vld;

    // Rotate toward the x axis; zero y counts as not positive
    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;
    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= i_vld;
        end
        if (i_ce) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

`default_nettype wire
